>>> rtl/integer_to_ascii_formatter_core_assert.svh
// Assertion macros shared by the formatter RTL.
// In synthesis builds the macros expand to nothing.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ITOA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define ITOA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ITOA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/itoa_pkg.sv
package itoa_pkg;

   // Field and buffer sizes.
   localparam int DATA_W     = 32;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int NUM_CHARS  = 11;
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int WORK_W     = BCD_W + DATA_W;
   localparam int DD_STAGES  = 4;
   localparam int DD_STEP    = DATA_W / DD_STAGES;
   localparam int CNT_W      = 4;

   // Conversion modes.
   localparam logic [2:0] OP_SDEC  = 3'd0;
   localparam logic [2:0] OP_UDEC  = 3'd1;
   localparam logic [2:0] OP_HEX_L = 3'd2;
   localparam logic [2:0] OP_HEX_U = 3'd3;
   localparam logic [2:0] OP_PTR   = 3'd4;

   // ASCII codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_X     = 8'h78;

   typedef logic [7:0] char_type;
   typedef char_type [NUM_CHARS-1:0] line_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   // One conversion in flight: the raw value for hex, and the
   // BCD accumulator with the magnitude shifting into it for decimal.
   typedef struct packed {
      logic [2:0]        op;
      logic              neg;
      logic [DATA_W-1:0] val;
      logic [WORK_W-1:0] work;
   } pipe_type;

   // Eight iterations of shift-and-add-3 binary to BCD conversion.
   function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] work_arg);
      logic [WORK_W-1:0] w;
      w = work_arg;
      for (int s = 0; s < DD_STEP; s++) begin
         for (int d = 0; d < DEC_DIGITS; d++) begin
            if (w[DATA_W + 4*d +: 4] >= 4'd5) begin
               w[DATA_W + 4*d +: 4] = w[DATA_W + 4*d +: 4] + 4'd3;
            end
         end
         w = {w[WORK_W-2:0], 1'b0};
      end
      return w;
   endfunction

   // ASCII character of one hex digit.
   function automatic char_type hex_char(input logic [3:0] nib, input logic upper);
      char_type c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'b0000, nib};
      end else begin
         c = (upper ? CHAR_UA : CHAR_LA) + {4'b0000, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

>>> rtl/integer_to_ascii_formatter_core.sv
// Converts a 32-bit value to ASCII: signed or unsigned decimal, eight hex
// digits in lower or upper case, or "0x" and eight lower-case digits. The
// characters of one number leave most significant first, one per cycle on
// consecutive cycles, each shown for exactly one cycle with rsp_strobe high;
// the receiver cannot stall them, so it must take every strobed character.
// rsp_item.last marks the final character. A number has 8 characters for
// hex, 10 for pointer and 1 to 11 for decimal, and the single character
// result port limits the sustained rate to one character per cycle.
// Numbers are accepted back to back while busy is low into a seven-register
// pipeline (sign and magnitude, four double-dabble stages, character build,
// output shifter), and the first character is strobed once the number
// reaches the output shifter; busy rises once that pipeline is full behind
// the output shifter. Modes 5 to 7 are accepted and produce no characters.
`include "integer_to_ascii_formatter_core_assert.svh"

module integer_to_ascii_formatter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  itoa_pkg::req_type req_item,
   output logic              rsp_strobe,
   output itoa_pkg::rsp_type rsp_item
);
   import itoa_pkg::*;

   // Pipeline registers and their enables.
   pipe_type               pipe_ff [DD_STAGES+1];
   pipe_type               pipe_in [DD_STAGES+1];
   logic [DD_STAGES:0]     pipe_valid_ff;
   logic [DD_STAGES:0]     pipe_valid_in;
   logic [DD_STAGES+1:0]   pipe_en;

   logic                   fmt_valid_ff;
   logic                   fmt_valid_in;
   line_type               fmt_chars_ff;
   line_type               fmt_chars_in;
   logic [CNT_W-1:0]       fmt_count_ff;
   logic [CNT_W-1:0]       fmt_count_in;

   logic                   ser_valid_ff;
   logic                   ser_valid_in;
   line_type               ser_buf_ff;
   line_type               ser_buf_in;
   logic [CNT_W-1:0]       ser_rem_ff;
   logic [CNT_W-1:0]       ser_rem_in;
   logic                   ser_ready;
   logic                   ser_load;

   logic                   req_take;
   logic                   op_ok;
   logic                   in_neg;
   logic [DATA_W-1:0]      in_mag;

   // Output shifter can take a new line when empty or on its final character.
   assign ser_ready = !ser_valid_ff || (ser_rem_ff == CNT_W'(1));
   assign ser_load  = fmt_valid_ff && ser_ready;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      pipe_en[DD_STAGES+1] = !fmt_valid_ff || ser_ready;
      for (int i = DD_STAGES; i >= 0; i--) begin
         pipe_en[i] = !pipe_valid_ff[i] || pipe_en[i+1];
      end
   end

   assign busy     = !pipe_en[0];
   assign req_take = start && !busy;

   // Entry stage: sign split and two's complement magnitude.
   always_comb begin
      op_ok  = req_item.op inside {OP_SDEC, OP_UDEC, OP_HEX_L, OP_HEX_U, OP_PTR};
      in_neg = (req_item.op == OP_SDEC) && req_item.value[DATA_W-1];
      in_mag = in_neg ? (~req_item.value + DATA_W'(1)) : req_item.value;
      pipe_in[0].op   = req_item.op;
      pipe_in[0].neg  = in_neg;
      pipe_in[0].val  = req_item.value;
      pipe_in[0].work = {{BCD_W{1'b0}}, in_mag};
      pipe_valid_in[0] = pipe_en[0] ? (req_take && op_ok) : pipe_valid_ff[0];
      // Double-dabble stages, eight bits each.
      for (int i = 1; i <= DD_STAGES; i++) begin
         pipe_in[i].op    = pipe_ff[i-1].op;
         pipe_in[i].neg   = pipe_ff[i-1].neg;
         pipe_in[i].val   = pipe_ff[i-1].val;
         pipe_in[i].work  = dabble_step(pipe_ff[i-1].work);
         pipe_valid_in[i] = pipe_en[i] ? pipe_valid_ff[i-1] : pipe_valid_ff[i];
      end
   end

   // Character build: strip leading zeros, add sign or prefix, pick hex case.
   always_comb begin
      logic [3:0]       dig [DEC_DIGITS];
      logic [CNT_W-1:0] ndig;
      logic [3:0]       idx;
      line_type         dec_line;
      pipe_type         src;
      src      = pipe_ff[DD_STAGES];
      ndig     = CNT_W'(1);
      dec_line = '0;
      for (int k = 0; k < DEC_DIGITS; k++) begin
         dig[k] = src.work[DATA_W + 4*k +: 4];
      end
      for (int k = 0; k < DEC_DIGITS; k++) begin
         if (dig[k] != 4'd0) begin
            ndig = CNT_W'(k + 1);
         end
      end
      for (int p = 0; p < DEC_DIGITS; p++) begin
         idx = ndig - 4'd1 - 4'(p);
         if (4'(p) < ndig) begin
            dec_line[p] = CHAR_ZERO + {4'b0000, dig[idx]};
         end
      end
      fmt_chars_in = '0;
      fmt_count_in = '0;
      case (src.op)
         OP_SDEC: begin
            if (src.neg) begin
               fmt_chars_in[0] = CHAR_MINUS;
               for (int p = 0; p < DEC_DIGITS; p++) begin
                  fmt_chars_in[p+1] = dec_line[p];
               end
               fmt_count_in = ndig + CNT_W'(1);
            end else begin
               fmt_chars_in = dec_line;
               fmt_count_in = ndig;
            end
         end
         OP_UDEC: begin
            fmt_chars_in = dec_line;
            fmt_count_in = ndig;
         end
         OP_HEX_L, OP_HEX_U: begin
            for (int p = 0; p < HEX_DIGITS; p++) begin
               fmt_chars_in[p] = hex_char(src.val[4*(HEX_DIGITS-1-p) +: 4],
                                          src.op == OP_HEX_U);
            end
            fmt_count_in = CNT_W'(HEX_DIGITS);
         end
         OP_PTR: begin
            fmt_chars_in[0] = CHAR_ZERO;
            fmt_chars_in[1] = CHAR_X;
            for (int p = 0; p < HEX_DIGITS; p++) begin
               fmt_chars_in[p+2] = hex_char(src.val[4*(HEX_DIGITS-1-p) +: 4], 1'b0);
            end
            fmt_count_in = CNT_W'(HEX_DIGITS + 2);
         end
         default: begin
            fmt_chars_in = '0;
            fmt_count_in = '0;
         end
      endcase
      fmt_valid_in = pipe_en[DD_STAGES+1] ? pipe_valid_ff[DD_STAGES] : fmt_valid_ff;
   end

   // Output shifter: one character per cycle, first character at index zero.
   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_buf_in   = ser_buf_ff;
      ser_rem_in   = ser_rem_ff;
      if (ser_load) begin
         ser_valid_in = 1'b1;
         ser_buf_in   = fmt_chars_ff;
         ser_rem_in   = fmt_count_ff;
      end else if (ser_valid_ff) begin
         if (ser_rem_ff == CNT_W'(1)) begin
            ser_valid_in = 1'b0;
         end
         ser_buf_in = {8'h00, ser_buf_ff[NUM_CHARS-1:1]};
         ser_rem_in = ser_rem_ff - CNT_W'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
         fmt_valid_ff  <= 1'b0;
         ser_valid_ff  <= 1'b0;
         ser_rem_ff    <= '0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
         fmt_valid_ff  <= fmt_valid_in;
         ser_valid_ff  <= ser_valid_in;
         ser_rem_ff    <= ser_rem_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i <= DD_STAGES; i++) begin
         if (pipe_en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
      if (pipe_en[DD_STAGES+1]) begin
         fmt_chars_ff <= fmt_chars_in;
         fmt_count_ff <= fmt_count_in;
      end
      ser_buf_ff <= ser_buf_in;
   end

   // Result ports.
   assign rsp_strobe        = ser_valid_ff;
   assign rsp_item.char_out = ser_buf_ff[0];
   assign rsp_item.last     = (ser_rem_ff == CNT_W'(1));

   // Characters of one number leave on consecutive cycles.
   `ITOA_ASSERT_NEXT(a_chars_contiguous, clock, reset, rsp_strobe && !rsp_item.last, rsp_strobe)
   // The shifter never runs with an empty or oversized count.
   `ITOA_ASSERT_IMPL(a_rem_range, clock, reset, ser_valid_ff, (ser_rem_ff != '0) && (ser_rem_ff <= CNT_W'(NUM_CHARS)))
   // A built line waits while the shifter is busy.
   `ITOA_ASSERT_NEXT(a_fmt_holds, clock, reset, fmt_valid_ff && !ser_ready, fmt_valid_ff && $stable(fmt_count_ff))
   // An accepted number with a defined mode enters the pipeline.
   `ITOA_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy && (req_item.op <= OP_PTR), pipe_valid_ff[0])

endmodule
